@@ rtl/core/ftc_pkg.sv @@
// Shared types, constants and arithmetic helpers of the frustum culling tester.
`timescale 1ns / 1ps
package ftc_pkg;

  // Number format and plane count.
  localparam int VW         = 32;
  localparam int FRAC       = 16;
  localparam int PLANES     = 6;
  localparam int SQ_STEPS   = VW;
  localparam int DIV_STEPS  = VW + FRAC;
  localparam int ITW        = $clog2(DIV_STEPS);

  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // Request kinds.
  localparam logic [2:0] KIND_LOAD   = 3'd0;
  localparam logic [2:0] KIND_BUILD  = 3'd1;
  localparam logic [2:0] KIND_POINT  = 3'd2;
  localparam logic [2:0] KIND_SPHERE = 3'd3;
  localparam logic [2:0] KIND_BOX    = 3'd4;

  typedef struct packed {
    logic [2:0]        kind;
    logic [3:0]        index;
    logic signed [31:0] value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]       radius;
    logic [30:0]       half_x;
    logic [30:0]       half_y;
    logic [30:0]       half_z;
  } ftc_req_t;

  typedef struct packed {
    logic inside_res;
  } ftc_rsp_t;

  typedef enum logic [1:0] {
    SH_POINT,
    SH_SPHERE,
    SH_BOX
  } ftc_shape_e;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_START,
    DP_DMUL,
    DP_DACC,
    DP_BMUL,
    DP_BACC,
    DP_DADD,
    DP_CMP,
    DP_EMIT,
    DP_BRD,
    DP_BADD,
    DP_SQ,
    DP_SACC,
    DP_SQINIT,
    DP_SQSTEP,
    DP_DVINIT,
    DP_DVSTEP,
    DP_DWR,
    DP_PWR
  } ftc_op_e;

  typedef struct packed {
    ftc_op_e    op;
    logic [2:0] plane;
    logic [1:0] comp;
    ftc_shape_e shape;
  } ftc_cmd_t;

  typedef struct packed {
    logic root_zero;
  } ftc_sts_t;

  // Matrix row that plane p combines with row 3.
  function automatic logic [1:0] plane_row(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0, 3'd1: r = 2'd2;
      3'd2, 3'd3: r = 2'd0;
      default:    r = 2'd1;
    endcase
    return r;
  endfunction

  // True when plane p adds the row, false when it subtracts it.
  function automatic logic plane_plus(input logic [2:0] p);
    logic s;
    case (p)
      3'd0, 3'd2, 3'd5: s = 1'b1;
      default:          s = 1'b0;
    endcase
    return s;
  endfunction

  // Saturating signed add.
  function automatic logic [VW-1:0] sadd(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? VMIN : VMAX;
    end
    return s[VW-1:0];
  endfunction

  // Saturating signed subtract, exact before the final clamp.
  function automatic logic [VW-1:0] ssub(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? VMIN : VMAX;
    end
    return s[VW-1:0];
  endfunction

  // Magnitude of a signed value as unsigned.
  function automatic logic [VW-1:0] mag(input logic [VW-1:0] a);
    return a[VW-1] ? (~a + 1'b1) : a;
  endfunction

  // Signed value from sign and wide magnitude, saturated.
  function automatic logic [VW-1:0] fmag(input logic neg, input logic [2*VW-1:0] m);
    logic [2*VW-1:0] lim;
    logic [VW-1:0]   v;
    lim = {{VW{1'b0}}, VMAX} + {{(2*VW-1){1'b0}}, neg};
    v   = (m > lim) ? lim[VW-1:0] : m[VW-1:0];
    return neg ? (~v + 1'b1) : v;
  endfunction

endpackage

@@ rtl/core/ftc_if.sv @@
// Request and response channel interfaces of the frustum culling tester.
`timescale 1ns / 1ps
interface ftc_req_if;
  logic              valid;
  logic              ready;
  ftc_pkg::ftc_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ftc_rsp_if;
  logic              valid;
  logic              ready;
  ftc_pkg::ftc_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/ftc_datapath.sv @@
// Datapath: matrix and plane stores, shared multiplier, square root and divider.
`timescale 1ns / 1ps
module ftc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ftc_pkg::ftc_cmd_t cmd_i,
  input  ftc_pkg::ftc_req_t req_data_i,
  output ftc_pkg::ftc_rsp_t rsp_data_o,
  output ftc_pkg::ftc_sts_t sts_o
);
  import ftc_pkg::*;

  logic [VW-1:0]   matrix_q [16];
  logic [VW-1:0]   plane_q  [PLANES*4];
  logic [VW-1:0]   pos_q    [3];
  logic [VW-2:0]   half_q   [3];
  logic [VW-2:0]   rad_q;
  logic [VW-1:0]   w_q      [4];
  logic [VW-1:0]   tmp_q;
  logic [2*VW-1:0] prod_q;
  logic            psign_q;
  logic [VW-1:0]   dist_q;
  logic [VW-1:0]   lim_q;
  logic            inside_q;
  logic            rsp_q;
  logic [2*VW-1:0] sum_q;
  logic [2*VW-1:0] sx_q;
  logic [VW+2:0]   srem_q;
  logic [VW-1:0]   root_q;
  logic [DIV_STEPS-1:0] num_q;
  logic [VW-1:0]   drem_q;
  logic [DIV_STEPS-1:0] quo_q;

  logic [3:0]      m_addr;
  logic [VW-1:0]   m_rd;
  logic [VW-1:0]   pl_rd;
  logic [VW-1:0]   pl_abs;
  logic [VW-1:0]   mul_a;
  logic [VW-1:0]   mul_b;
  logic            mul_s;
  logic [VW-1:0]   smul;
  logic [VW-1:0]   bound;
  logic [VW+2:0]   sq_r;
  logic [VW+2:0]   sq_t;
  logic [VW:0]     dv_r;

  // Store reads: one address each, chosen by the command.
  assign m_addr = (cmd_i.op == DP_BRD) ? {plane_row(cmd_i.plane), cmd_i.comp}
                                       : {2'd3, cmd_i.comp};
  assign m_rd   = matrix_q[m_addr];
  assign pl_rd  = plane_q[{cmd_i.plane, cmd_i.comp}];
  assign pl_abs = (mag(pl_rd) == VMIN) ? VMAX : mag(pl_rd);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = mag(pl_rd);
    mul_b = mag(pos_q[cmd_i.comp]);
    mul_s = pl_rd[VW-1] ^ pos_q[cmd_i.comp][VW-1];
    case (cmd_i.op)
      DP_BMUL: begin
        mul_a = pl_abs;
        mul_b = {1'b0, half_q[cmd_i.comp]};
        mul_s = 1'b0;
      end
      DP_SQ: begin
        mul_a = mag(w_q[cmd_i.comp]);
        mul_b = mag(w_q[cmd_i.comp]);
        mul_s = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Scaled and saturated product, culling bound, and the iteration steps.
  assign smul = fmag(psign_q, prod_q >> FRAC);
  always_comb begin
    case (cmd_i.shape)
      SH_SPHERE: bound = ~{1'b0, rad_q} + 1'b1;
      SH_BOX:    bound = ~lim_q + 1'b1;
      default:   bound = '0;
    endcase
  end
  assign sq_r = {srem_q[VW:0], sx_q[2*VW-1:2*VW-2]};
  assign sq_t = {1'b0, root_q, 2'b01};
  assign dv_r = {drem_q, num_q[DIV_STEPS-1]};

  // Stores and control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) matrix_q[i] <= '0;
      for (int i = 0; i < PLANES*4; i++) plane_q[i] <= '0;
      inside_q <= 1'b1;
    end else begin
      case (cmd_i.op)
        DP_LOAD:  matrix_q[req_data_i.index] <= req_data_i.value;
        DP_START: inside_q <= 1'b1;
        DP_CMP: begin
          if ($signed(dist_q) < $signed(bound)) inside_q <= 1'b0;
        end
        DP_PWR:   plane_q[{cmd_i.plane, cmd_i.comp}] <= w_q[cmd_i.comp];
        default: begin
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_START: begin
        pos_q[0] <= req_data_i.pos_x;
        pos_q[1] <= req_data_i.pos_y;
        pos_q[2] <= req_data_i.pos_z;
        half_q[0] <= req_data_i.half_x;
        half_q[1] <= req_data_i.half_y;
        half_q[2] <= req_data_i.half_z;
        rad_q <= req_data_i.radius;
        dist_q <= '0;
        lim_q <= '0;
      end
      DP_DMUL, DP_BMUL, DP_SQ: begin
        prod_q  <= {{VW{1'b0}}, mul_a} * {{VW{1'b0}}, mul_b};
        psign_q <= mul_s;
      end
      DP_DACC: dist_q <= sadd(dist_q, smul);
      DP_BACC: lim_q <= sadd(lim_q, smul);
      DP_DADD: dist_q <= sadd(dist_q, pl_rd);
      DP_CMP: begin
        dist_q <= '0;
        lim_q <= '0;
      end
      DP_EMIT: rsp_q <= inside_q;
      DP_BRD:  tmp_q <= m_rd;
      DP_BADD: begin
        w_q[cmd_i.comp] <= plane_plus(cmd_i.plane) ? sadd(m_rd, tmp_q) : ssub(m_rd, tmp_q);
        sum_q <= '0;
      end
      DP_SACC: sum_q <= sum_q + prod_q;
      DP_SQINIT: begin
        sx_q <= sum_q;
        srem_q <= '0;
        root_q <= '0;
      end
      DP_SQSTEP: begin
        sx_q <= sx_q << 2;
        if (sq_r >= sq_t) begin
          srem_q <= sq_r - sq_t;
          root_q <= {root_q[VW-2:0], 1'b1};
        end else begin
          srem_q <= sq_r;
          root_q <= {root_q[VW-2:0], 1'b0};
        end
      end
      DP_DVINIT: begin
        num_q  <= {mag(w_q[cmd_i.comp]), {FRAC{1'b0}}};
        drem_q <= '0;
        quo_q  <= '0;
      end
      DP_DVSTEP: begin
        num_q <= num_q << 1;
        if (dv_r >= {1'b0, root_q}) begin
          drem_q <= dv_r[VW-1:0] - root_q;
          quo_q  <= {quo_q[DIV_STEPS-2:0], 1'b1};
        end else begin
          drem_q <= dv_r[VW-1:0];
          quo_q  <= {quo_q[DIV_STEPS-2:0], 1'b0};
        end
      end
      DP_DWR: w_q[cmd_i.comp] <= fmag(w_q[cmd_i.comp][VW-1],
                                      {{(2*VW-DIV_STEPS){1'b0}}, quo_q});
      default: begin
      end
    endcase
  end

  assign rsp_data_o.inside_res = rsp_q;
  assign sts_o.root_zero       = (root_q == '0);

endmodule

@@ rtl/core/ftc_ctrl.sv @@
// Controller: sequences matrix loads, plane builds and shape tests.
`timescale 1ns / 1ps
module ftc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic [2:0]        req_kind_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output ftc_pkg::ftc_cmd_t cmd_o,
  input  ftc_pkg::ftc_sts_t sts_i
);
  import ftc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_TMUL, S_TACC, S_BMUL, S_BACC, S_TD, S_TCMP, S_TDONE,
    S_BRD, S_BADD, S_SQ, S_SACC, S_SQI, S_SQS, S_CHK, S_DVI, S_DVS, S_DWR, S_PWR
  } state_e;

  localparam logic [2:0] LAST_PLANE = 3'(PLANES - 1);

  state_e           state_q;
  logic [2:0]       p_q;
  logic [1:0]       c_q;
  logic [ITW-1:0]   iter_q;
  ftc_shape_e       shape_q;
  logic             rsp_valid_q;
  logic             emit;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign emit = (state_q == S_TDONE) && (!rsp_valid_q || rsp_ready_i);

  // Datapath command decoded from the state.
  always_comb begin
    cmd_o.plane = p_q;
    cmd_o.comp  = c_q;
    cmd_o.shape = shape_q;
    cmd_o.op    = DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_kind_i == KIND_LOAD) cmd_o.op = DP_LOAD;
          else if (req_kind_i inside {KIND_POINT, KIND_SPHERE, KIND_BOX}) cmd_o.op = DP_START;
        end
      end
      S_TMUL:  cmd_o.op = DP_DMUL;
      S_TACC:  cmd_o.op = DP_DACC;
      S_BMUL:  cmd_o.op = DP_BMUL;
      S_BACC:  cmd_o.op = DP_BACC;
      S_TD: begin
        cmd_o.op   = DP_DADD;
        cmd_o.comp = 2'd3;
      end
      S_TCMP:  cmd_o.op = DP_CMP;
      S_TDONE: cmd_o.op = emit ? DP_EMIT : DP_NOP;
      S_BRD:   cmd_o.op = DP_BRD;
      S_BADD:  cmd_o.op = DP_BADD;
      S_SQ:    cmd_o.op = DP_SQ;
      S_SACC:  cmd_o.op = DP_SACC;
      S_SQI:   cmd_o.op = DP_SQINIT;
      S_SQS:   cmd_o.op = DP_SQSTEP;
      S_DVI:   cmd_o.op = DP_DVINIT;
      S_DVS:   cmd_o.op = DP_DVSTEP;
      S_DWR:   cmd_o.op = DP_DWR;
      S_PWR:   cmd_o.op = DP_PWR;
      default: cmd_o.op = DP_NOP;
    endcase
  end

  // State, counters and the response valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      p_q         <= '0;
      c_q         <= '0;
      iter_q      <= '0;
      shape_q     <= SH_POINT;
      rsp_valid_q <= 1'b0;
    end else begin
      if (emit) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          p_q <= '0;
          c_q <= '0;
          if (req_valid_i) begin
            case (req_kind_i)
              KIND_BUILD:  state_q <= S_BRD;
              KIND_POINT: begin
                shape_q <= SH_POINT;
                state_q <= S_TMUL;
              end
              KIND_SPHERE: begin
                shape_q <= SH_SPHERE;
                state_q <= S_TMUL;
              end
              KIND_BOX: begin
                shape_q <= SH_BOX;
                state_q <= S_TMUL;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_TMUL: state_q <= S_TACC;
        S_TACC, S_BACC: begin
          if (state_q == S_TACC && shape_q == SH_BOX) begin
            state_q <= S_BMUL;
          end else if (c_q == 2'd2) begin
            state_q <= S_TD;
          end else begin
            c_q <= c_q + 2'd1;
            state_q <= S_TMUL;
          end
        end
        S_BMUL: state_q <= S_BACC;
        S_TD:   state_q <= S_TCMP;
        S_TCMP: begin
          c_q <= '0;
          if (p_q == LAST_PLANE) begin
            state_q <= S_TDONE;
          end else begin
            p_q <= p_q + 3'd1;
            state_q <= S_TMUL;
          end
        end
        S_TDONE: if (emit) state_q <= S_IDLE;
        S_BRD:  state_q <= S_BADD;
        S_BADD: begin
          if (c_q == 2'd3) begin
            c_q <= '0;
            state_q <= S_SQ;
          end else begin
            c_q <= c_q + 2'd1;
            state_q <= S_BRD;
          end
        end
        S_SQ: state_q <= S_SACC;
        S_SACC: begin
          if (c_q == 2'd2) begin
            state_q <= S_SQI;
          end else begin
            c_q <= c_q + 2'd1;
            state_q <= S_SQ;
          end
        end
        S_SQI: begin
          iter_q  <= ITW'(SQ_STEPS - 1);
          state_q <= S_SQS;
        end
        S_SQS: begin
          if (iter_q == '0) state_q <= S_CHK;
          else iter_q <= iter_q - 1'b1;
        end
        S_CHK: begin
          c_q <= '0;
          state_q <= sts_i.root_zero ? S_PWR : S_DVI;
        end
        S_DVI: begin
          iter_q  <= ITW'(DIV_STEPS - 1);
          state_q <= S_DVS;
        end
        S_DVS: begin
          if (iter_q == '0) state_q <= S_DWR;
          else iter_q <= iter_q - 1'b1;
        end
        S_DWR: begin
          if (c_q == 2'd3) begin
            c_q <= '0;
            state_q <= S_PWR;
          end else begin
            c_q <= c_q + 2'd1;
            state_q <= S_DVI;
          end
        end
        S_PWR: begin
          if (c_q == 2'd3) begin
            c_q <= '0;
            if (p_q == LAST_PLANE) begin
              state_q <= S_IDLE;
            end else begin
              p_q <= p_q + 3'd1;
              state_q <= S_BRD;
            end
          end else begin
            c_q <= c_q + 2'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A build or a test request makes the block busy on the next cycle.
  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && req_kind_i >= KIND_BUILD && req_kind_i <= KIND_BOX)
    |=> !req_ready_o) else $error("block not busy after accepting work");

  // A new response only comes out of the final test state.
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == S_TDONE)
    else $error("response raised outside the final test state");

  // The square root runs no more steps than the root has bits.
  a_sqrt_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQS |-> iter_q <= ITW'(SQ_STEPS - 1))
    else $error("square root step count out of range");

  // The plane counter never passes the last plane.
  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_q <= LAST_PLANE) else $error("plane counter out of range");

endmodule

@@ rtl/core/frustum_culling_tester_unit.sv @@
// Top level of the frustum culling tester: controller plus datapath.
//
//  channel | dir | payload                                     | accepted when
//  req_i   | in  | kind, index, value, pos_*, radius, half_*   | valid && ready
//  rsp_o   | out | inside_res                                  | valid && ready
//
// A matrix load is written as it is accepted. Point, sphere and box tests
// share the single multiplier, visiting six planes with one product and then
// one saturating add per component; a box test adds its extent product too.
// A plane build runs the 32-step square root per plane, then four 48-step
// restoring divisions unless the normal is zero.
// Reset clears the matrix and plane stores to zero; one request is in work at
// a time, and a finished result waits in the output register while the next
// request is accepted, stalling only a test that finishes before it is taken.
`timescale 1ns / 1ps
module frustum_culling_tester_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  ftc_req_if.sink   req_i,
  ftc_rsp_if.source rsp_o
);
  import ftc_pkg::*;

  ftc_cmd_t cmd;
  ftc_sts_t sts;

  ftc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.data.kind),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ftc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_data_i (req_i.data),
    .rsp_data_o (rsp_o.data),
    .sts_o      (sts)
  );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the frustum culling tester unit.
`timescale 1ns / 1ps
module tb;
  import ftc_pkg::*;

  // Kinds the block is expected to ignore.
  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_B = 3'd6;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;

  localparam int  ITEM_TARGET  = 1800;
  localparam int  STALL_LIMIT  = 20000;
  localparam int  DRAIN_CYCLES = 1700;
  localparam int  HOLD_CYCLES  = 400;
  localparam longint VPOS = 64'sd2147483647;
  localparam longint VNEG = -64'sd2147483648;

  // Scoreboard: keeps its own copy of the matrix and plane stores.
  class cull_scoreboard;
    longint mat[16];
    longint pl[24];
    bit     inside_q[$];
    int     errors;

    function new();
      foreach (mat[i]) mat[i] = 0;
      foreach (pl[i]) pl[i] = 0;
      errors = 0;
    endfunction

    function longint clamp32(longint a);
      if (a > VPOS) return VPOS;
      if (a < VNEG) return VNEG;
      return a;
    endfunction

    function longint unsigned magnitude(longint a);
      return (a < 0) ? longint'(-a) : a;
    endfunction

    function longint from_magnitude(bit neg, longint unsigned m);
      longint unsigned lim;
      longint unsigned v;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      v = (m > lim) ? lim : m;
      return neg ? -longint'(v) : longint'(v);
    endfunction

    function longint fx_mul(longint a, longint b);
      longint unsigned p;
      p = (magnitude(a) * magnitude(b)) >> FRAC;
      return from_magnitude((a < 0) != (b < 0), p);
    endfunction

    // Six planes from row 3 plus or minus rows 0..2, then normalized.
    function void build_planes();
      int rows[6];
      bit plus[6];
      bit [127:0] sum;
      bit [127:0] c2;
      longint unsigned root;
      longint unsigned cand;
      longint b;
      rows = '{2, 2, 0, 0, 1, 1};
      plus = '{1, 0, 1, 0, 0, 1};
      for (int p = 0; p < 6; p++) begin
        for (int c = 0; c < 4; c++) begin
          b = mat[rows[p] * 4 + c];
          if (!plus[p]) b = -b;
          pl[p * 4 + c] = clamp32(mat[12 + c] + b);
        end
        sum = '0;
        for (int c = 0; c < 3; c++) begin
          sum += 128'(magnitude(pl[p * 4 + c])) * 128'(magnitude(pl[p * 4 + c]));
        end
        root = 0;
        for (int k = 63; k >= 0; k--) begin
          cand = root | (64'd1 << k);
          c2 = 128'(cand) * 128'(cand);
          if (sum >= c2) root = cand;
        end
        if (root != 0) begin
          for (int c = 0; c < 4; c++) begin
            pl[p * 4 + c] = from_magnitude(pl[p * 4 + c] < 0,
                                           (magnitude(pl[p * 4 + c]) << FRAC) / root);
          end
        end
      end
    endfunction

    // Inside flag of a point, sphere or box against the stored planes.
    function bit shape_inside(ftc_req_t r);
      longint pt[3];
      longint half[3];
      longint d;
      longint lim;
      longint ext;
      bit in_view;
      pt[0] = longint'($signed(r.pos_x));
      pt[1] = longint'($signed(r.pos_y));
      pt[2] = longint'($signed(r.pos_z));
      half[0] = longint'({1'b0, r.half_x});
      half[1] = longint'({1'b0, r.half_y});
      half[2] = longint'({1'b0, r.half_z});
      in_view = 1'b1;
      for (int p = 0; p < 6; p++) begin
        d = clamp32(fx_mul(pl[p * 4], pt[0]) + fx_mul(pl[p * 4 + 1], pt[1]));
        d = clamp32(d + fx_mul(pl[p * 4 + 2], pt[2]));
        d = clamp32(d + pl[p * 4 + 3]);
        lim = 0;
        if (r.kind == KIND_SPHERE) begin
          lim = -longint'({1'b0, r.radius});
        end else if (r.kind == KIND_BOX) begin
          ext = 0;
          for (int c = 0; c < 3; c++) begin
            ext = clamp32(ext + fx_mul(from_magnitude(1'b0, magnitude(pl[p * 4 + c])),
                                       half[c]));
          end
          lim = -ext;
        end
        if (d < lim) in_view = 1'b0;
      end
      return in_view;
    endfunction

    function void note_request(ftc_req_t r);
      case (r.kind)
        KIND_LOAD: mat[r.index] = longint'($signed(r.value));
        KIND_BUILD: build_planes();
        KIND_POINT, KIND_SPHERE, KIND_BOX: inside_q.push_back(shape_inside(r));
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_response(ftc_rsp_t s);
      bit want;
      if (inside_q.size() == 0) begin
        report($sformatf("unexpected response inside_res=%0b", s.inside_res));
      end else begin
        want = inside_q.pop_front();
        if (s.inside_res !== want) begin
          report($sformatf("inside_res=%0b, expected %0b", s.inside_res, want));
        end
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  ftc_req_if req_if ();
  ftc_rsp_if rsp_if ();

  cull_scoreboard sb;
  int  sent_count;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_left;
  bit  hold_done;
  int  quiet_cycles;

  frustum_culling_tester_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Clock generation.
  always #1 clk_i = ~clk_i;

  // Monitor: note accepted requests and check accepted responses.
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) sb.note_request(req_if.data);
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Response side: random back-pressure and one long hold-off.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (!hold_done && sent_count >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Drive one request, called and returning at a falling edge.
  task send_request(ftc_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
  endtask

  function automatic ftc_req_t blank_request(logic [2:0] kind);
    ftc_req_t r;
    r = '0;
    r.kind = kind;
    return r;
  endfunction

  // Q16.16 value in one of several ranges.
  function automatic logic [31:0] rand_value(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($urandom_range(0, 524288)) - 32'd262144;
      2: return 32'($urandom_range(0, 33554432)) - 32'd16777216;
      default: begin
        case ($urandom_range(0, 3))
          0: return VMIN;
          1: return VMAX;
          2: return 32'h0001_0000;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [30:0] rand_extent(int mode);
    case (mode)
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 262144));
      2: return 31'($urandom_range(0, 16777216));
      default: return $urandom_range(0, 1) ? 31'h7fff_ffff : 31'h0;
    endcase
  endfunction

  function automatic ftc_req_t rand_shape(int mode);
    ftc_req_t r;
    r = blank_request(3'(KIND_POINT + $urandom_range(0, 2)));
    r.pos_x  = rand_value(mode);
    r.pos_y  = rand_value(mode);
    r.pos_z  = rand_value(mode);
    r.radius = rand_extent(mode);
    r.half_x = rand_extent(mode);
    r.half_y = rand_extent(mode);
    r.half_z = rand_extent(mode);
    r.value  = $urandom;
    r.index  = 4'($urandom);
    return r;
  endfunction

  // Directed requests: tests before a build, spare kinds, zero normals, extremes.
  task run_directed();
    ftc_req_t r;
    send_request(blank_request(KIND_POINT));
    r = blank_request(KIND_SPHERE);
    r.pos_x = VMIN;
    r.radius = 31'h7fff_ffff;
    send_request(r);
    r = blank_request(KIND_BOX);
    r.pos_y = VMAX;
    send_request(r);
    send_request(blank_request(KIND_SPARE_A));
    send_request(blank_request(KIND_SPARE_B));
    r = blank_request(KIND_SPARE_C);
    r.value = '1;
    send_request(r);
    send_request(blank_request(KIND_BUILD));
    send_request(blank_request(KIND_POINT));
    r = blank_request(KIND_LOAD);
    r.index = 4'd0;
    r.value = VMIN;
    send_request(r);
    r.index = 4'd15;
    r.value = VMAX;
    send_request(r);
    r.index = 4'd10;
    r.value = 32'h0001_0000;
    send_request(r);
    send_request(blank_request(KIND_BUILD));
    r = blank_request(KIND_POINT);
    r.pos_x = VMAX;
    r.pos_y = VMIN;
    r.pos_z = VMAX;
    send_request(r);
    r.kind = KIND_SPHERE;
    r.radius = 31'h7fff_ffff;
    send_request(r);
    r.kind = KIND_BOX;
    r.half_x = 31'h7fff_ffff;
    r.half_y = 31'h7fff_ffff;
    r.half_z = 31'h7fff_ffff;
    send_request(r);
    r.pos_x = VMIN;
    r.half_x = 31'h0;
    send_request(r);
  endtask

  // Random part: mostly load, build and test sequences, some noise.
  task run_random();
    ftc_req_t r;
    int mode;
    while (sent_count < ITEM_TARGET) begin
      if (sent_count >= 1400) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent_count >= 700) begin
        send_idle_pct = 52;
        recv_idle_pct = 38;
      end
      if ($urandom_range(0, 99) < 88) begin
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 16; i++) begin
          if ($urandom_range(0, 9) != 0) begin
            r = blank_request(KIND_LOAD);
            r.index = 4'(i);
            r.value = rand_value($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : mode);
            r.pos_x = $urandom;
            r.radius = 31'($urandom);
            send_request(r);
          end
        end
        send_request(blank_request(KIND_BUILD));
        repeat ($urandom_range(5, 25)) send_request(rand_shape($urandom_range(0, 3)));
      end else begin
        r = rand_shape(0);
        r.kind = 3'($urandom);
        if (r.kind == KIND_BUILD && $urandom_range(0, 1)) r.kind = KIND_LOAD;
        send_request(r);
      end
    end
  endtask

  initial begin
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    sent_count = 0;
    hold_left = 0;
    hold_done = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 38;
    recv_idle_pct = 52;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    run_directed();
    run_random();
    req_if.valid <= 1'b0;
    while (sb.inside_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
